>>> rtl/core/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared codes and controller/datapath interface types for the huffman code
// builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OVF    = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_CNT_RD,
    ACT_CNT_WR,
    ACT_CLEAR,
    ACT_QRY_RD,
    ACT_BLD_INIT,
    ACT_SCAN_RD,
    ACT_SCAN_WR,
    ACT_ONE,
    ACT_HEAP_INIT,
    ACT_HP_LD,
    ACT_HP_START,
    ACT_HP_NEXT,
    ACT_SD_RD,
    ACT_SD_CMP,
    ACT_TK_RD,
    ACT_TK_A,
    ACT_TK_B,
    ACT_PUT_INIT,
    ACT_PU_RD,
    ACT_PU_CMP,
    ACT_MRG_END,
    ACT_WK_INIT,
    ACT_WK_RD,
    ACT_WK_A,
    ACT_WK_B,
    ACT_BLD_DONE,
    ACT_RESP
  } dp_act_t;

  typedef struct packed {
    dp_act_t act;
    status_t st;
    logic    hit;
  } hcb_cmd_t;

  typedef struct packed {
    op_t  op;
    logic sym_ok;
    logic total_full;
    logic built;
    logic qry_vld;
    logic scan_last;
    logic n_zero;
    logic n_one;
    logic p_zero;
    logic sd_done;
    logic pu_done;
    logic size_one;
    logic wk_leaf;
    logic k_zero;
    logic out_free;
  } hcb_stat_t;

endpackage

>>> rtl/core/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer for count, query, clear and the heap based code build.
// ----------------------------------------------------------------------------
module hcb_ctrl import hcb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hcb_stat_t stat,
  output hcb_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_CNT_RD, S_CNT_WR, S_QRY_RD, S_SCAN_RD, S_SCAN_WR, S_BLD_CHK,
    S_HP_LD, S_HP_START, S_HP_NEXT, S_SD_RD, S_SD_CMP, S_TK_RD, S_TK_LATCH,
    S_PUT_INIT, S_PU_RD, S_PU_CMP, S_MRG_END, S_WK_INIT, S_WK_RD, S_WK_A, S_WK_B,
    S_FIN, S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RET_HEAPIFY, RET_TAKE_A, RET_TAKE_B
  } ret_t;

  state_t  state_r, state_nxt;
  ret_t    ret_r, ret_nxt;
  logic    second_r, second_nxt;
  status_t st_r, st_nxt;
  logic    hit_r, hit_nxt;
  dp_act_t act;

  assign in_ready = (state_r == S_IDLE);
  assign cmd.act  = act;
  assign cmd.st   = st_r;
  assign cmd.hit  = hit_r;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    second_nxt = second_r;
    st_nxt     = st_r;
    hit_nxt    = hit_r;
    act        = ACT_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act       = ACT_LATCH;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        hit_nxt = 1'b0;
        st_nxt  = ST_OK;
        case (stat.op)
          OP_COUNT: begin
            if (!stat.sym_ok) begin
              st_nxt    = ST_ABSENT;
              state_nxt = S_RESP;
            end else if (stat.total_full) begin
              st_nxt    = ST_OVF;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_CNT_RD;
            end
          end
          OP_BUILD: begin
            act       = ACT_BLD_INIT;
            state_nxt = S_SCAN_RD;
          end
          OP_QUERY: begin
            if (!stat.sym_ok || !stat.built || !stat.qry_vld) begin
              st_nxt    = ST_ABSENT;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_QRY_RD;
            end
          end
          default: begin
            act       = ACT_CLEAR;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_CNT_RD: begin
        act       = ACT_CNT_RD;
        state_nxt = S_CNT_WR;
      end
      S_CNT_WR: begin
        act       = ACT_CNT_WR;
        state_nxt = S_RESP;
      end
      S_QRY_RD: begin
        act       = ACT_QRY_RD;
        hit_nxt   = 1'b1;
        state_nxt = S_RESP;
      end
      S_SCAN_RD: begin
        act       = ACT_SCAN_RD;
        state_nxt = S_SCAN_WR;
      end
      S_SCAN_WR: begin
        act       = ACT_SCAN_WR;
        state_nxt = stat.scan_last ? S_BLD_CHK : S_SCAN_RD;
      end
      S_BLD_CHK: begin
        if (stat.n_zero) begin
          st_nxt    = ST_EMPTY;
          state_nxt = S_RESP;
        end else if (stat.n_one) begin
          act       = ACT_ONE;
          state_nxt = S_RESP;
        end else begin
          act       = ACT_HEAP_INIT;
          state_nxt = S_HP_LD;
        end
      end
      S_HP_LD: begin
        act       = ACT_HP_LD;
        state_nxt = S_HP_START;
      end
      S_HP_START: begin
        act       = ACT_HP_START;
        ret_nxt   = RET_HEAPIFY;
        state_nxt = S_SD_RD;
      end
      S_HP_NEXT: begin
        act       = ACT_HP_NEXT;
        state_nxt = S_HP_LD;
      end
      S_SD_RD: begin
        act       = ACT_SD_RD;
        state_nxt = S_SD_CMP;
      end
      S_SD_CMP: begin
        act = ACT_SD_CMP;
        if (!stat.sd_done) begin
          state_nxt = S_SD_RD;
        end else begin
          case (ret_r)
            RET_HEAPIFY: begin
              second_nxt = 1'b0;
              state_nxt  = stat.p_zero ? S_TK_RD : S_HP_NEXT;
            end
            RET_TAKE_A: begin
              second_nxt = 1'b1;
              state_nxt  = S_TK_RD;
            end
            default: state_nxt = S_PUT_INIT;
          endcase
        end
      end
      S_TK_RD: begin
        act       = ACT_TK_RD;
        state_nxt = S_TK_LATCH;
      end
      S_TK_LATCH: begin
        act       = second_r ? ACT_TK_B : ACT_TK_A;
        ret_nxt   = second_r ? RET_TAKE_B : RET_TAKE_A;
        state_nxt = S_SD_RD;
      end
      S_PUT_INIT: begin
        act       = ACT_PUT_INIT;
        state_nxt = S_PU_RD;
      end
      S_PU_RD: begin
        act       = ACT_PU_RD;
        state_nxt = S_PU_CMP;
      end
      S_PU_CMP: begin
        act       = ACT_PU_CMP;
        state_nxt = stat.pu_done ? S_MRG_END : S_PU_RD;
      end
      S_MRG_END: begin
        act        = ACT_MRG_END;
        second_nxt = 1'b0;
        state_nxt  = stat.size_one ? S_WK_INIT : S_TK_RD;
      end
      S_WK_INIT: begin
        act       = ACT_WK_INIT;
        state_nxt = S_WK_RD;
      end
      S_WK_RD: begin
        act       = ACT_WK_RD;
        state_nxt = S_WK_A;
      end
      S_WK_A: begin
        act = ACT_WK_A;
        if (!stat.wk_leaf) begin
          state_nxt = S_WK_B;
        end else begin
          state_nxt = stat.k_zero ? S_FIN : S_WK_RD;
        end
      end
      S_WK_B: begin
        act       = ACT_WK_B;
        state_nxt = S_WK_RD;
      end
      S_FIN: begin
        act       = ACT_BLD_DONE;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          act       = ACT_RESP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= RET_HEAPIFY;
      second_r <= 1'b0;
      st_r     <= ST_OK;
      hit_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      second_r <= second_nxt;
      st_r     <= st_nxt;
      hit_r    <= hit_nxt;
    end
  end

  a_resp_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !stat.out_free) |=> (state_r == S_RESP))
    else $error("result dropped while output register busy");

endmodule

>>> rtl/core/hcb_datapath.sv
// ----------------------------------------------------------------------------
// hcb_datapath
// Histogram, heap, tree and code table stores with their working registers.
// ----------------------------------------------------------------------------
module hcb_datapath import hcb_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int COUNT_BITS    = 32,
  parameter int MAX_CODE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  hcb_cmd_t    cmd,
  output hcb_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_code_length,
  output logic [63:0] out_code_bits,
  output logic [8:0]  out_distinct_symbols
);

  localparam int SYM_W   = $clog2(ALPHABET_SIZE);
  localparam int NODES   = 2 * ALPHABET_SIZE - 1;
  localparam int NODE_W  = $clog2(NODES);
  localparam int HEAP_W  = SYM_W;
  localparam int SIZE_W  = SYM_W + 1;
  localparam int IX_W    = HEAP_W + 2;
  localparam int DEPTH_W = SYM_W + 1;
  localparam int LEN_W   = $clog2(MAX_CODE_BITS + 1);
  localparam int HE_W    = NODE_W + COUNT_BITS;
  localparam int KID_W   = 2 * NODE_W;
  localparam int WALK_W  = DEPTH_W + MAX_CODE_BITS;
  localparam int CODE_W  = LEN_W + MAX_CODE_BITS;

  typedef logic [HE_W-1:0] heap_ent_t;

  // stores
  logic [COUNT_BITS-1:0] cnt_mem  [ALPHABET_SIZE];
  heap_ent_t             heap_mem [ALPHABET_SIZE];
  logic [KID_W-1:0]      kid_mem  [NODES];
  logic [WALK_W-1:0]     walk_mem [NODES];
  logic [CODE_W-1:0]     code_mem [ALPHABET_SIZE];

  // control state
  logic [ALPHABET_SIZE-1:0] cnt_vld_r, code_vld_r;
  logic [COUNT_BITS-1:0]    total_r;
  logic [SIZE_W-1:0]        distinct_r;
  logic                     built_r;
  logic                     out_valid_r;

  // working registers
  op_t                   op_r;
  logic [7:0]            byte_r;
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic                  cnt_rvld_r;
  heap_ent_t             rda_r, rdb_r, cur_r, a_r, b_r;
  logic [KID_W-1:0]      kid_rd_r;
  logic [WALK_W-1:0]     walk_rd_r;
  logic [CODE_W-1:0]     code_rd_r;
  logic [SYM_W-1:0]      s_r, first_sym_r;
  logic [SIZE_W-1:0]     n_r, size_r;
  logic [HEAP_W-1:0]     p_r, pos_r;
  logic [NODE_W-1:0]     next_r, k_r;
  logic [1:0]            out_status_r;
  logic [6:0]            out_len_r;
  logic [63:0]           out_bits_r;
  logic [8:0]            out_dist_r;

  logic [SYM_W-1:0] sym;
  logic             sym_ok;
  assign sym    = byte_r[SYM_W-1:0];
  assign sym_ok = ({1'b0, byte_r} < 9'(ALPHABET_SIZE));

  // heap comparisons
  logic [COUNT_BITS-1:0] f_cur, f_l, f_r, f_min;
  logic [IX_W-1:0]       l_ix, r_ix;
  logic                  have_l, have_r, pick_l, pick_r, sd_done, pu_up;
  logic [HEAP_W-1:0]     parent;

  assign f_cur  = cur_r[COUNT_BITS-1:0];
  assign f_l    = rda_r[COUNT_BITS-1:0];
  assign f_r    = rdb_r[COUNT_BITS-1:0];
  assign l_ix   = {1'b0, pos_r, 1'b1};
  assign r_ix   = l_ix + 1'b1;
  assign have_l = l_ix < IX_W'(size_r);
  assign have_r = r_ix < IX_W'(size_r);
  assign pick_l = have_l && (f_l < f_cur);
  assign f_min  = pick_l ? f_l : f_cur;
  assign pick_r = have_r && (f_r < f_min);
  assign sd_done = !pick_l && !pick_r;
  assign parent = (pos_r - 1'b1) >> 1;
  assign pu_up  = (pos_r != '0) && (f_cur < f_l);

  // tree walk fields
  logic [DEPTH_W-1:0]        wk_d;
  logic [MAX_CODE_BITS-1:0]  wk_code;
  logic [NODE_W-1:0]         wk_left, wk_right;
  logic                      wk_leaf;
  assign wk_d     = walk_rd_r[WALK_W-1:MAX_CODE_BITS];
  assign wk_code  = walk_rd_r[MAX_CODE_BITS-1:0];
  assign wk_left  = kid_rd_r[KID_W-1:NODE_W];
  assign wk_right = kid_rd_r[NODE_W-1:0];
  assign wk_leaf  = k_r < NODE_W'(n_r);

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.op         = op_r;
    stat.sym_ok     = sym_ok;
    stat.total_full = &total_r;
    stat.built      = built_r;
    stat.qry_vld    = code_vld_r[sym];
    stat.scan_last  = (s_r == SYM_W'(ALPHABET_SIZE - 1));
    stat.n_zero     = (n_r == '0);
    stat.n_one      = (n_r == SIZE_W'(1));
    stat.p_zero     = (p_r == '0);
    stat.sd_done    = sd_done;
    stat.pu_done    = !pu_up;
    stat.size_one   = (size_r == SIZE_W'(1));
    stat.wk_leaf    = wk_leaf;
    stat.k_zero     = (k_r == '0);
    stat.out_free   = out_free;
  end

  // memory port selection
  logic                  cnt_re, cnt_we;
  logic [SYM_W-1:0]      cnt_a;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic                  heap_re, heap_we;
  logic [HEAP_W-1:0]     heap_ra, heap_rb, heap_wa;
  heap_ent_t             heap_wd;
  logic                  kid_we;
  logic [NODE_W-1:0]     kid_wa;
  logic [KID_W-1:0]      kid_wd;
  logic                  walk_we;
  logic [NODE_W-1:0]     walk_wa;
  logic [WALK_W-1:0]     walk_wd;
  logic                  code_we;
  logic [SYM_W-1:0]      code_wa;
  logic [CODE_W-1:0]     code_wd;

  always_comb begin
    cnt_re  = 1'b0;
    cnt_we  = 1'b0;
    cnt_a   = sym;
    cnt_wd  = (cnt_rvld_r ? cnt_rd_r : '0) + 1'b1;
    heap_re = 1'b0;
    heap_we = 1'b0;
    heap_ra = p_r;
    heap_rb = p_r;
    heap_wa = pos_r;
    heap_wd = cur_r;
    kid_we  = 1'b0;
    kid_wa  = NODE_W'(n_r);
    kid_wd  = {NODE_W'(s_r), NODE_W'(0)};
    walk_we = 1'b0;
    walk_wa = wk_left;
    walk_wd = {wk_d + 1'b1, wk_code << 1};
    code_we = 1'b0;
    code_wa = SYM_W'(wk_left);
    code_wd = {LEN_W'(wk_d), wk_code};
    case (cmd.act)
      ACT_CNT_RD: cnt_re = 1'b1;
      ACT_CNT_WR: cnt_we = 1'b1;
      ACT_SCAN_RD: begin
        cnt_re = 1'b1;
        cnt_a  = s_r;
      end
      ACT_SCAN_WR: begin
        heap_we = cnt_rvld_r;
        heap_wa = HEAP_W'(n_r);
        heap_wd = {NODE_W'(n_r), cnt_rd_r};
        kid_we  = cnt_rvld_r;
      end
      ACT_ONE: begin
        code_we = 1'b1;
        code_wa = first_sym_r;
        code_wd = '0;
      end
      ACT_HP_LD: heap_re = 1'b1;
      ACT_SD_RD: begin
        heap_re = 1'b1;
        heap_ra = HEAP_W'(l_ix);
        heap_rb = HEAP_W'(r_ix);
      end
      ACT_SD_CMP: begin
        heap_we = 1'b1;
        heap_wd = pick_r ? rdb_r : (pick_l ? rda_r : cur_r);
      end
      ACT_TK_RD: begin
        heap_re = 1'b1;
        heap_ra = '0;
        heap_rb = HEAP_W'(size_r - 1'b1);
      end
      ACT_PUT_INIT: begin
        kid_we = 1'b1;
        kid_wa = next_r;
        kid_wd = {a_r[HE_W-1:COUNT_BITS], b_r[HE_W-1:COUNT_BITS]};
      end
      ACT_PU_RD: begin
        heap_re = 1'b1;
        heap_ra = parent;
      end
      ACT_PU_CMP: begin
        heap_we = 1'b1;
        heap_wd = pu_up ? rda_r : cur_r;
      end
      ACT_WK_INIT: begin
        walk_we = 1'b1;
        walk_wa = next_r - 1'b1;
        walk_wd = '0;
      end
      ACT_WK_A: begin
        walk_we = !wk_leaf;
        code_we = wk_leaf && (32'(wk_d) <= MAX_CODE_BITS);
      end
      ACT_WK_B: begin
        walk_we = 1'b1;
        walk_wa = wk_right;
        walk_wd = {wk_d + 1'b1, (wk_code << 1) | MAX_CODE_BITS'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_a] <= cnt_wd;
    if (cnt_re) begin
      cnt_rd_r   <= cnt_mem[cnt_a];
      cnt_rvld_r <= cnt_vld_r[cnt_a];
    end
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) begin
      rda_r <= heap_mem[heap_ra];
      rdb_r <= heap_mem[heap_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (kid_we) kid_mem[kid_wa] <= kid_wd;
    if (walk_we) walk_mem[walk_wa] <= walk_wd;
    if (cmd.act == ACT_WK_RD) begin
      kid_rd_r  <= kid_mem[k_r];
      walk_rd_r <= walk_mem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (code_we) code_mem[code_wa] <= code_wd;
    if (cmd.act == ACT_QRY_RD) code_rd_r <= code_mem[sym];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r   <= '0;
      code_vld_r  <= '0;
      total_r     <= '0;
      distinct_r  <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: loaded by the sequencer, emptied by a transfer
      if (cmd.act == ACT_RESP) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.act)
        ACT_CNT_WR: begin
          cnt_vld_r[sym] <= 1'b1;
          total_r        <= total_r + 1'b1;
          if (!cnt_rvld_r) distinct_r <= distinct_r + 1'b1;
          built_r        <= 1'b0;
        end
        ACT_CLEAR: begin
          cnt_vld_r  <= '0;
          code_vld_r <= '0;
          total_r    <= '0;
          distinct_r <= '0;
          built_r    <= 1'b0;
        end
        ACT_BLD_INIT: begin
          code_vld_r <= '0;
          built_r    <= 1'b0;
        end
        ACT_ONE: begin
          code_vld_r[first_sym_r] <= 1'b1;
          built_r                 <= 1'b1;
        end
        ACT_WK_A: begin
          if (code_we) code_vld_r[code_wa] <= 1'b1;
        end
        ACT_BLD_DONE: built_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_LATCH: begin
        op_r   <= op_t'(in_operation);
        byte_r <= in_data_byte;
      end
      ACT_BLD_INIT: begin
        n_r <= '0;
        s_r <= '0;
      end
      ACT_SCAN_WR: begin
        if (cnt_rvld_r) begin
          if (n_r == '0) first_sym_r <= s_r;
          n_r <= n_r + 1'b1;
        end
        s_r <= s_r + 1'b1;
      end
      ACT_HEAP_INIT: begin
        size_r <= n_r;
        p_r    <= HEAP_W'((n_r - SIZE_W'(2)) >> 1);
        next_r <= NODE_W'(n_r);
      end
      ACT_HP_START: begin
        cur_r <= rda_r;
        pos_r <= p_r;
      end
      ACT_HP_NEXT: p_r <= p_r - 1'b1;
      ACT_SD_CMP: begin
        if (pick_r) pos_r <= HEAP_W'(r_ix);
        else if (pick_l) pos_r <= HEAP_W'(l_ix);
      end
      ACT_TK_A: begin
        a_r    <= rda_r;
        cur_r  <= rdb_r;
        size_r <= size_r - 1'b1;
        pos_r  <= '0;
      end
      ACT_TK_B: begin
        b_r    <= rda_r;
        cur_r  <= rdb_r;
        size_r <= size_r - 1'b1;
        pos_r  <= '0;
      end
      ACT_PUT_INIT: begin
        cur_r  <= {next_r, a_r[COUNT_BITS-1:0] + b_r[COUNT_BITS-1:0]};
        pos_r  <= HEAP_W'(size_r);
        size_r <= size_r + 1'b1;
      end
      ACT_PU_CMP: begin
        if (pu_up) pos_r <= parent;
      end
      ACT_MRG_END: next_r <= next_r + 1'b1;
      ACT_WK_INIT: k_r <= next_r - 1'b1;
      ACT_WK_A: begin
        if (wk_leaf) k_r <= k_r - 1'b1;
      end
      ACT_WK_B: k_r <= k_r - 1'b1;
      ACT_RESP: begin
        out_status_r <= cmd.st;
        out_len_r    <= cmd.hit ? 7'(code_rd_r[CODE_W-1:MAX_CODE_BITS]) : 7'd0;
        out_bits_r   <= cmd.hit ? 64'(code_rd_r[MAX_CODE_BITS-1:0]) : 64'd0;
        out_dist_r   <= 9'(distinct_r);
      end
      default: ;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_code_length      = out_len_r;
  assign out_code_bits        = out_bits_r;
  assign out_distinct_symbols = out_dist_r;

  a_no_count_past_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_CNT_WR) |-> !(&total_r))
    else $error("byte counted at total limit");

  a_resp_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_RESP) |-> out_free)
    else $error("result loaded over pending result");

  a_distinct_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    COUNT_BITS'(distinct_r) <= total_r)
    else $error("distinct symbols exceed total count");

endmodule

>>> rtl/core/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// Byte histogram with min-heap huffman code construction and code lookup.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one transfer carries an operation and
//   a byte: count byte, build codes, query symbol code, or clear
//   result channel (out_valid/out_ready): exactly one result per input
//   transfer, in order: status, code length, code bits, distinct symbols
//   sequencing, one item at a time through a single sequencer
//     count: accept, decode, store read, store write, result
//     query: accept, decode, code table read, result
//     clear, rejected items: accept, decode, result
//     build: histogram scan with a store read and write per symbol, then a
//     heap read and compare per level for every sift and insert, then a
//     read and one or two steps per tree node for the code walk; the single
//     write port of each store sets the pace
//   a new item is taken as soon as the sequencer is idle, even while the
//   previous result still waits in the output register
//   receiver stall: the finished item parks until its result can be loaded
// reset: histogram, total, code table and built flag cleared at once via
// valid bits; no clearing pass is needed
// ----------------------------------------------------------------------------
module huffman_code_builder import hcb_pkg::*; #(
  parameter int ALPHABET_SIZE = 256,
  parameter int COUNT_BITS    = 32,
  parameter int MAX_CODE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_code_length,
  output logic [63:0] out_code_bits,
  output logic [8:0]  out_distinct_symbols
);

  // command and status between sequencer and datapath
  hcb_cmd_t  cmd;
  hcb_stat_t stat;

  hcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stores, heap arithmetic and the output register
  hcb_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_BITS    (COUNT_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_operation         (in_operation),
    .in_data_byte         (in_data_byte),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_code_length      (out_code_length),
    .out_code_bits        (out_code_bits),
    .out_distinct_symbols (out_distinct_symbols)
  );

endmodule
